[src/conv3x3_bias_relu_stream_core_defines.svh]
// Assertion macros shared by the convolution core RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef CONV3X3_BIAS_RELU_STREAM_CORE_DEFINES_SVH
`define CONV3X3_BIAS_RELU_STREAM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CBR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBR_ASSERT(lbl, prop, msg) \
    `CBR_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define CBR_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define CBR_ASSERT(lbl, prop, msg)
`endif
`endif

[src/cbr_pkg.sv]
// Shared types, widths and helpers of the 3x3 convolution core.
// No dependencies; used by cbr_regs, cbr_front, cbr_back and the top level.
`timescale 1ns / 1ps
package cbr_pkg;
    localparam int PIX_W      = 32;
    localparam int KW_W       = 16;
    localparam int KROW_W     = 48;
    localparam int PROD_W     = 48;
    localparam int PART_W     = 50;
    localparam int TOT_W      = 52;
    localparam int FRAC_SHIFT = 14;
    localparam int SUM_W      = 38;
    localparam int ACC_W      = 40;
    localparam int ACC_SUM_W  = 41;
    localparam int VAL_W      = 31;
    localparam int COORD_W    = 8;
    localparam int FS_W       = 9;
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 6;
    localparam int BIAS_W     = 32;

    localparam logic [FS_W-1:0] FRAME_RESET = 9'd224;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_K_TOP = 3'd0,
        REG_K_MID = 3'd1,
        REG_K_BOT = 3'd2,
        REG_BIAS  = 3'd3,
        REG_FRAME = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [KROW_W-1:0]        k_top;
        logic [KROW_W-1:0]        k_mid;
        logic [KROW_W-1:0]        k_bot;
        logic signed [BIAS_W-1:0] bias;
        logic [FS_W-1:0]          frame_size;
        logic                     restart;
    } t_cfg;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel;
        logic                    produce;
        logic                    first;
        logic                    lastch;
        logic                    last;
    } t_slot;

    // Pick weight column col (0..2) out of a packed kernel row.
    function automatic logic signed [KW_W-1:0] kweight(input logic [KROW_W-1:0] row,
                                                      input int unsigned col);
        kweight = row[col*KW_W +: KW_W];
    endfunction
endpackage

[src/cbr_in_if.sv]
// Pixel input channel of the convolution core: valid/ready plus one raster slot.
// No dependencies.
`timescale 1ns / 1ps
interface cbr_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] pixel;
    logic              first_channel;
    logic              last_channel;

    modport source (output valid, pixel, first_channel, last_channel, input ready);
    modport sink   (input valid, pixel, first_channel, last_channel, output ready);
endinterface

[src/cbr_out_if.sv]
// Result channel of the convolution core: valid/ready plus one activation.
// No dependencies.
`timescale 1ns / 1ps
interface cbr_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] value;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
    logic        last;

    modport source (output valid, value, out_row, out_col, last, input ready);
    modport sink   (input valid, value, out_row, out_col, last, output ready);
endinterface

[src/cbr_regs.sv]
// APB configuration registers of the convolution core.
// Depends on cbr_pkg.
`timescale 1ns / 1ps
module cbr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbr_pkg::APB_AW-1:0]  paddr,
    input  logic [cbr_pkg::APB_DW-1:0]  pwdata,
    output logic [cbr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output cbr_pkg::t_cfg               o_cfg
);
    import cbr_pkg::*;

    logic [KROW_W-1:0]        r_k_top, r_k_mid, r_k_bot;
    logic signed [BIAS_W-1:0] r_bias;
    logic [FS_W-1:0]          r_frame;
    logic                     w_wr;
    t_reg_idx                 w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:3]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_top <= '0;
            r_k_mid <= '0;
            r_k_bot <= '0;
            r_bias  <= '0;
            r_frame <= FRAME_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_K_TOP: r_k_top <= pwdata[KROW_W-1:0];
                REG_K_MID: r_k_mid <= pwdata[KROW_W-1:0];
                REG_K_BOT: r_k_bot <= pwdata[KROW_W-1:0];
                REG_BIAS:  r_bias  <= signed'(pwdata[BIAS_W-1:0]);
                REG_FRAME: r_frame <= pwdata[FS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_K_TOP: prdata = APB_DW'(r_k_top);
            REG_K_MID: prdata = APB_DW'(r_k_mid);
            REG_K_BOT: prdata = APB_DW'(r_k_bot);
            REG_BIAS:  prdata = APB_DW'(unsigned'(r_bias));
            REG_FRAME: prdata = APB_DW'(r_frame);
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.k_top      = r_k_top;
        o_cfg.k_mid      = r_k_mid;
        o_cfg.k_bot      = r_k_bot;
        o_cfg.bias       = r_bias;
        o_cfg.frame_size = r_frame;
        // restart the raster on the same edge that takes a new frame size
        o_cfg.restart    = w_wr && (w_idx == REG_FRAME);
    end
endmodule

[src/cbr_front.sv]
// Front end of the convolution core: accept raster slots, track position, classify.
// Depends on cbr_pkg and cbr_in_if.
`timescale 1ns / 1ps
`include "conv3x3_bias_relu_stream_core_defines.svh"
module cbr_front #(
    parameter  int MAX_SIZE = 256,
    localparam int CW       = $clog2(MAX_SIZE + 2)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbr_pkg::t_cfg   i_cfg,
    cbr_in_if.sink          i_pix,
    input  logic            i_full,
    output logic            o_push,
    output cbr_pkg::t_slot  o_slot,
    output logic [CW-1:0]   o_col,
    output logic [CW-1:0]   o_orow,
    output logic [CW-1:0]   o_ocol
);
    import cbr_pkg::*;

    logic [CW-1:0] r_row, r_col, n_row, n_col;
    logic [CW-1:0] w_size, w_edge;
    logic          w_border;

    // clamp the frame size into 1 .. MAX_SIZE
    always_comb begin
        if (i_cfg.frame_size == '0) begin
            w_size = CW'(1);
        end else if (32'(i_cfg.frame_size) > 32'(MAX_SIZE)) begin
            w_size = CW'(MAX_SIZE);
        end else begin
            w_size = CW'(i_cfg.frame_size);
        end
    end
    assign w_edge = w_size + CW'(1);

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    assign w_border = (r_row == '0) || (r_row >= w_edge) || (r_col == '0) || (r_col >= w_edge);

    always_comb begin
        o_slot.pixel   = w_border ? '0 : i_pix.pixel;
        o_slot.produce = (r_row >= CW'(2)) && (r_col >= CW'(2))
                         && (r_row <= w_edge) && (r_col <= w_edge);
        o_slot.first   = i_pix.first_channel;
        o_slot.lastch  = i_pix.last_channel;
        o_slot.last    = (r_row == w_edge) && (r_col == w_edge);
    end
    assign o_col  = r_col;
    assign o_orow = r_row - CW'(2);
    assign o_ocol = r_col - CW'(2);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cfg.restart) begin
            n_row = '0;
            n_col = '0;
        end else if (o_push) begin
            if (r_col >= w_edge) begin
                n_col = '0;
                n_row = (r_row >= w_edge) ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    `CBR_ASSERT(a_col_in_frame, r_col <= w_edge, "column counter past frame edge")
    `CBR_ASSERT(a_row_in_frame, r_row <= w_edge, "row counter past frame edge")
endmodule

[src/cbr_fifo.sv]
// Short register queue between the front end and the compute back end.
// Depends on the assertion header only.
`timescale 1ns / 1ps
`include "conv3x3_bias_relu_stream_core_defines.svh"
module cbr_fifo #(
    parameter  int DW    = 40,
    parameter  int DEPTH = 4,
    localparam int PW    = $clog2(DEPTH),
    localparam int NW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [DW-1:0] o_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_count <= r_count + NW'(i_push) - NW'(i_pop);
        end
    end

    `CBR_ASSERT(a_fifo_bound, r_count <= NW'(DEPTH), "queue count beyond depth")
endmodule

[src/cbr_back.sv]
// Compute back end: line buffers, 3x3 window, multiply-add tree, accumulator, ReLU.
// Depends on cbr_pkg and cbr_out_if.
`timescale 1ns / 1ps
`include "conv3x3_bias_relu_stream_core_defines.svh"
module cbr_back #(
    parameter  int MAX_SIZE = 256,
    localparam int CW       = $clog2(MAX_SIZE + 2),
    localparam int LD       = MAX_SIZE + 2,
    localparam int AD       = MAX_SIZE * MAX_SIZE,
    localparam int AW       = $clog2(MAX_SIZE * MAX_SIZE)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbr_pkg::t_cfg   i_cfg,
    input  logic            i_empty,
    output logic            o_pop,
    input  cbr_pkg::t_slot  i_slot,
    input  logic [CW-1:0]   i_col,
    input  logic [CW-1:0]   i_orow,
    input  logic [CW-1:0]   i_ocol,
    cbr_out_if.source       o_res
);
    import cbr_pkg::*;

    // line buffer pair: upper row in the high half, lower row in the low half
    logic [2*PIX_W-1:0]      r_line [LD];
    logic [2*PIX_W-1:0]      r_line_rd;
    logic [ACC_W-1:0]        r_acc_mem [AD];
    logic [ACC_W-1:0]        r_acc_rd;

    logic                    w_en;
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    t_slot                   r_s1, r_s2, r_s3, r_s4, r_s5;
    logic [CW-1:0]           r_c1;
    logic [CW-1:0]           r_orow1, r_orow2, r_orow3, r_orow4, r_orow5;
    logic [CW-1:0]           r_ocol1, r_ocol2, r_ocol3, r_ocol4, r_ocol5;
    logic signed [PIX_W-1:0] r_win [6];
    logic signed [PIX_W-1:0] w_col [3];
    logic [KROW_W-1:0]       w_krow [3];
    logic signed [PROD_W-1:0] w_prod [9];
    logic signed [PROD_W-1:0] r_prod [9];
    logic signed [PART_W-1:0] r_part [3];
    logic signed [TOT_W-1:0]  w_tot;
    logic signed [SUM_W-1:0]  r_sum;
    logic [AW-1:0]            w_idx3, r_idx4;
    logic signed [ACC_W-1:0]  w_base, w_new, r_acc5;
    logic signed [ACC_SUM_W-1:0] w_t, w_v;
    logic [VAL_W-1:0]         w_val, r_value;
    logic [COORD_W-1:0]       r_out_row, r_out_col;
    logic                     r_last;

    // the whole back end stalls together on a full output register
    assign w_en  = !r_out_valid || o_res.ready;
    assign o_pop = w_en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5 && r_s5.produce && r_s5.lastch;
        end
    end

    // stage 1: take the slot, read the line pair at its column
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1      <= i_slot;
            r_c1      <= i_col;
            r_orow1   <= i_orow;
            r_ocol1   <= i_ocol;
            r_line_rd <= r_line[i_col];
            if (r_v1) begin
                r_line[r_c1] <= {r_line_rd[PIX_W-1:0], r_s1.pixel};
            end
        end
    end

    assign w_col[0] = signed'(r_line_rd[2*PIX_W-1:PIX_W]);
    assign w_col[1] = signed'(r_line_rd[PIX_W-1:0]);
    assign w_col[2] = r_s1.pixel;
    assign w_krow[0] = i_cfg.k_top;
    assign w_krow[1] = i_cfg.k_mid;
    assign w_krow[2] = i_cfg.k_bot;

    // shift the window one column left and load the new column
    always_ff @(posedge i_clk) begin
        if (w_en && r_v1) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i]     <= r_win[3+i];
                r_win[3+i]   <= w_col[i];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_prod[3*a]   = PROD_W'(r_win[a])   * PROD_W'(kweight(w_krow[a], 0));
            w_prod[3*a+1] = PROD_W'(r_win[3+a]) * PROD_W'(kweight(w_krow[a], 1));
            w_prod[3*a+2] = PROD_W'(w_col[a])   * PROD_W'(kweight(w_krow[a], 2));
        end
    end

    // stage 2: products; stage 3: row sums
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod  <= w_prod;
            r_s2    <= r_s1;
            r_orow2 <= r_orow1;
            r_ocol2 <= r_ocol1;
            for (int a = 0; a < 3; a++) begin
                r_part[a] <= PART_W'(r_prod[3*a]) + PART_W'(r_prod[3*a+1])
                             + PART_W'(r_prod[3*a+2]);
            end
            r_s3    <= r_s2;
            r_orow3 <= r_orow2;
            r_ocol3 <= r_ocol2;
        end
    end

    assign w_tot  = TOT_W'(r_part[0]) + TOT_W'(r_part[1]) + TOT_W'(r_part[2]);
    assign w_idx3 = AW'(r_orow3) * AW'(MAX_SIZE) + AW'(r_ocol3);

    // stage 4: scaled sum, accumulator read; read-modify-write closes here
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum   <= SUM_W'(w_tot >>> FRAC_SHIFT);
            r_s4    <= r_s3;
            r_orow4 <= r_orow3;
            r_ocol4 <= r_ocol3;
            r_idx4  <= w_idx3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc_rd <= r_acc_mem[w_idx3];
            if (r_v4 && r_s4.produce) begin
                r_acc_mem[r_idx4] <= w_new;
            end
        end
    end

    always_comb begin
        w_base = r_s4.first ? '0 : signed'(r_acc_rd);
        w_t    = ACC_SUM_W'(w_base) + ACC_SUM_W'(r_sum);
        if (w_t[ACC_SUM_W-1] != w_t[ACC_SUM_W-2]) begin
            w_new = w_t[ACC_SUM_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            w_new = w_t[ACC_W-1:0];
        end
    end

    // stage 5: bias, ReLU and clamp into the output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc5  <= w_new;
            r_s5    <= r_s4;
            r_orow5 <= r_orow4;
            r_ocol5 <= r_ocol4;
        end
    end

    always_comb begin
        w_v = ACC_SUM_W'(r_acc5) + ACC_SUM_W'(i_cfg.bias);
        if (w_v[ACC_SUM_W-1]) begin
            w_val = '0;
        end else if (|w_v[ACC_SUM_W-2:VAL_W]) begin
            w_val = '1;
        end else begin
            w_val = w_v[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_value   <= w_val;
            r_out_row <= COORD_W'(r_orow5);
            r_out_col <= COORD_W'(r_ocol5);
            r_last    <= r_s5.last;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.value   = r_value;
    assign o_res.out_row = r_out_row;
    assign o_res.out_col = r_out_col;
    assign o_res.last    = r_last;

    `CBR_ASSERT(a_result_source, $rose(r_out_valid) |-> $past(r_v5 && r_s5.produce && r_s5.lastch), "result without a producing last-channel slot")
    `CBR_ASSERT(a_stall_holds, (!w_en && r_v5) |=> r_v5, "stage five lost an item during a stall")
endmodule

[src/conv3x3_bias_relu_stream_core.sv]
// Top level of the streaming 3x3 convolution with bias and ReLU.
// Depends on cbr_pkg, cbr_in_if, cbr_out_if, cbr_regs, cbr_front, cbr_fifo, cbr_back.
`timescale 1ns / 1ps
// The core takes one input-channel plane as a zero-padded raster of (S+2) x (S+2) slots,
// S = frame_size clamped to 1 .. MAX_SIZE, one slot per request; it forces the outer ring
// to zero itself. While the output register is not stalled it sustains one request per cycle:
// the line buffer pair is read once and written once per slot through one read port and
// one write port, the nine multiplies run in parallel in one stage, and the accumulator
// memory does one read and one write per cycle.
// Each accepted slot passes through the queue, the back-end stages and the output register.
// Slot (r, c) with r, c >= 2 finishes output position (r-2, c-2); results
// appear only on planes flagged last_channel. The per-position accumulator memory
// (MAX_SIZE^2 x 40 bits) is never cleared: a plane flagged first_channel starts each
// position from zero, so every position must see a first-channel plane before it is
// accumulated into. Line buffers need no clearing either, since rows 0 and 1 of each
// raster rewrite them before any window uses them. Write configuration only while idle;
// a frame_size write restarts the raster at slot (0, 0).
module conv3x3_bias_relu_stream_core #(
    parameter int MAX_SIZE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cbr_in_if.sink                      i_pix,
    cbr_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbr_pkg::APB_AW-1:0]  paddr,
    input  logic [cbr_pkg::APB_DW-1:0]  pwdata,
    output logic [cbr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import cbr_pkg::*;

    localparam int CW     = $clog2(MAX_SIZE + 2);
    localparam int QW     = $bits(t_slot) + 3 * CW;
    localparam int QDEPTH = 4;

    t_cfg          w_cfg;
    t_slot         w_slot_in, w_slot_out;
    logic [CW-1:0] w_col_in, w_orow_in, w_ocol_in;
    logic [CW-1:0] w_col_out, w_orow_out, w_ocol_out;
    logic          w_push, w_pop, w_full, w_empty;
    logic [QW-1:0] w_q_in, w_q_out;

    // configuration registers; restart pulses on a frame_size write
    cbr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // front: accept a request whenever the queue has room, tag its raster position
    cbr_front #(.MAX_SIZE(MAX_SIZE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_pix   (i_pix),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_slot  (w_slot_in),
        .o_col   (w_col_in),
        .o_orow  (w_orow_in),
        .o_ocol  (w_ocol_in)
    );

    // queue decouples the input handshake from back-end stalls
    assign w_q_in = {w_slot_in, w_col_in, w_orow_in, w_ocol_in};
    assign {w_slot_out, w_col_out, w_orow_out, w_ocol_out} = w_q_out;

    cbr_fifo #(.DW(QW), .DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_q_out)
    );

    // back: window, multiply-add, accumulate, bias and ReLU, output register
    cbr_back #(.MAX_SIZE(MAX_SIZE)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_slot  (w_slot_out),
        .i_col   (w_col_out),
        .i_orow  (w_orow_out),
        .i_ocol  (w_ocol_out),
        .o_res   (o_res)
    );
endmodule

[dv/tb_top.sv]
// Self-checking testbench of the streaming 3x3 convolution core with bias and ReLU.
// Depends on cbr_pkg, cbr_in_if, cbr_out_if and conv3x3_bias_relu_stream_core.
`timescale 1ns / 1ps
module tb_top;
    import cbr_pkg::*;

    localparam int      MAX_SIZE  = 256;
    localparam int      LINE_D    = MAX_SIZE + 2;
    localparam longint  CYC_LIMIT = 200000;
    localparam longint  VMAX      = 64'sd2147483647;

    typedef struct {
        logic signed [31:0] pixel;
        logic               first;
        logic               lastch;
    } t_pix_req;

    typedef struct {
        logic [30:0] value;
        logic [7:0]  row;
        logic [7:0]  col;
        logic        last;
    } t_act;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    cbr_in_if  pix_ch();
    cbr_out_if res_ch();

    conv3x3_bias_relu_stream_core #(.MAX_SIZE(MAX_SIZE)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_ch.sink), .o_res(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    // Pending requests and expected activations.
    t_pix_req pix_q[$];
    t_act     act_q[$];
    longint   cyc = 0;
    int       errors = 0;
    bit       pix_taken = 1'b0;
    bit       stim_done = 1'b0;

    // Predictor state.
    logic [47:0]        k_rows[3];
    logic signed [31:0] bias_m;
    logic [8:0]         fsize_m;
    longint             line_up[LINE_D];
    longint             line_lo[LINE_D];
    longint             win[6];
    longint             acc_mem[MAX_SIZE*MAX_SIZE];
    int unsigned        row_c, col_c;

    // Generator side: which accumulator positions were started by a first channel.
    bit                 gen_started[MAX_SIZE*MAX_SIZE];
    int                 gen_items = 0;

    function automatic int unsigned eff_size(logic [8:0] fs);
        if (fs == 0) return 1;
        if (fs > MAX_SIZE) return MAX_SIZE;
        return fs;
    endfunction

    function automatic longint tap(logic [47:0] row, int col);
        logic signed [15:0] w;
        w = row[col*16 +: 16];
        return longint'(w);
    endfunction

    // Advance the convolution state by one raster slot and queue any activation.
    function automatic void conv_step(t_pix_req q);
        int unsigned s, lim, r, c, idx;
        longint p, prod, acc, v;
        longint cv[3];
        t_act a;
        s = eff_size(fsize_m);
        lim = s + 1;
        r = row_c;
        c = col_c;
        p = (r == 0 || r >= lim || c == 0 || c >= lim) ? 0 : longint'(q.pixel);
        cv[0] = line_up[c];
        cv[1] = line_lo[c];
        line_up[c] = line_lo[c];
        line_lo[c] = p;
        cv[2] = p;
        if (r >= 2 && c >= 2 && r <= lim && c <= lim) begin
            prod = 0;
            for (int i = 0; i < 3; i++) begin
                prod += win[i] * tap(k_rows[i], 0);
                prod += win[3+i] * tap(k_rows[i], 1);
                prod += cv[i] * tap(k_rows[i], 2);
            end
            idx = (r - 2) * MAX_SIZE + (c - 2);
            acc = (q.first ? 64'sd0 : acc_mem[idx]) + (prod >>> FRAC_SHIFT);
            if (acc > longint'(ACC_MAX)) acc = longint'(ACC_MAX);
            if (acc < longint'(ACC_MIN)) acc = longint'(ACC_MIN);
            acc_mem[idx] = acc;
            if (q.lastch) begin
                v = acc + longint'(bias_m);
                if (v < 0) v = 0;
                if (v > VMAX) v = VMAX;
                a.value = v[30:0];
                a.row = 8'(r - 2);
                a.col = 8'(c - 2);
                a.last = (r == lim && c == lim);
                act_q.push_back(a);
            end
        end
        for (int i = 0; i < 3; i++) begin
            win[i] = win[3+i];
            win[3+i] = cv[i];
        end
        if (c >= lim) begin
            col_c = 0;
            row_c = (r >= lim) ? 0 : r + 1;
        end else begin
            col_c = c + 1;
        end
    endfunction

    // Register write: setup then access cycle; mirror the value once it lands.
    task automatic reg_write(t_reg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = APB_AW'(int'(idx) * 8);
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_K_TOP: k_rows[0] = val[47:0];
            REG_K_MID: k_rows[1] = val[47:0];
            REG_K_BOT: k_rows[2] = val[47:0];
            REG_BIAS:  bias_m = val[31:0];
            REG_FRAME: begin
                fsize_m = val[8:0];
                row_c = 0;
                col_c = 0;
            end
            default: ;
        endcase
    endtask

    // Hold until every request is taken and every activation has come out.
    task automatic drain();
        while (pix_q.size() != 0 || act_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pixel(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'hffff_ffff;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [47:0] rand_kernel(int mode);
        logic [47:0] k;
        for (int i = 0; i < 3; i++) begin
            case (mode)
                0: k[i*16 +: 16] = 16'($urandom);
                1: k[i*16 +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
                default: k[i*16 +: 16] = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            endcase
        end
        return k;
    endfunction

    // Queue one full padded plane; force first_channel where a position is not started.
    task automatic add_plane(int pmode, bit pfirst, bit plast);
        int unsigned s, lim, idx;
        t_pix_req q;
        s = eff_size(fsize_m);
        lim = s + 1;
        for (int unsigned r = 0; r <= lim; r++) begin
            for (int unsigned c = 0; c <= lim; c++) begin
                q.pixel = rand_pixel(pmode);
                q.first = pfirst || ($urandom_range(0, 15) == 0);
                q.lastch = plast || ($urandom_range(0, 19) == 0);
                if (r >= 2 && c >= 2) begin
                    idx = (r - 2) * MAX_SIZE + (c - 2);
                    if (!gen_started[idx]) q.first = 1'b1;
                    gen_started[idx] = 1'b1;
                end
                pix_q.push_back(q);
                gen_items++;
            end
        end
    endtask

    task automatic add_slot(logic [31:0] pix, bit f, bit l);
        t_pix_req q;
        q.pixel = pix;
        q.first = f;
        q.lastch = l;
        pix_q.push_back(q);
        gen_items++;
    endtask

    // Idle windows: no gaps on either side for a stretch, one long receiver hold-off.
    bit quiet;
    assign quiet = (cyc > 3600 && cyc < 4200);

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Request side: take note of each accepted request and predict its result.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            conv_step(pix_q[0]);
            pix_taken <= 1'b1;
        end else begin
            pix_taken <= 1'b0;
        end
    end

    // Drive requests: hold valid until taken, then advance the queue.
    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        pix_ch.first_channel = 1'b0;
        pix_ch.last_channel = 1'b0;
    end

    always @(negedge i_clk) begin
        if (pix_taken) begin
            void'(pix_q.pop_front());
            pix_ch.valid = 1'b0;
        end
        if (!pix_ch.valid) begin
            if (i_rst_n && pix_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 32)) begin
                pix_ch.valid = 1'b1;
                pix_ch.pixel = pix_q[0].pixel;
                pix_ch.first_channel = pix_q[0].first;
                pix_ch.last_channel = pix_q[0].lastch;
            end
        end
    end

    // Result side: random ready, plus one long hold-off once the sender has a backlog.
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;

    initial res_ch.ready = 1'b0;

    always @(negedge i_clk) begin
        if (!hold_done && pix_q.size() > 100) begin
            hold_done = 1'b1;
            hold_cnt = 3000;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            res_ch.ready = 1'b0;
        end else begin
            res_ch.ready = i_rst_n && (quiet || $urandom_range(0, 99) >= 32);
        end
    end

    // Compare each delivered activation against the oldest prediction.
    always @(posedge i_clk) begin
        t_act e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (act_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected activation row %0d col %0d value %h",
                             res_ch.out_row, res_ch.out_col, res_ch.value);
            end else begin
                e = act_q.pop_front();
                if (res_ch.value !== e.value || res_ch.out_row !== e.row ||
                    res_ch.out_col !== e.col || res_ch.last !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp v=%h r=%0d c=%0d l=%b got v=%h r=%0d c=%0d l=%b",
                                 e.value, e.row, e.col, e.last, res_ch.value,
                                 res_ch.out_row, res_ch.out_col, res_ch.last);
                end
            end
        end
    end

    initial begin
        int pmode, nplanes;
        k_rows[0] = '0; k_rows[1] = '0; k_rows[2] = '0;
        bias_m = '0;
        fsize_m = FRAME_RESET;
        row_c = 0; col_c = 0;
        foreach (line_up[i]) begin
            line_up[i] = 0;
            line_lo[i] = 0;
        end
        foreach (win[i]) win[i] = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme weights and pixels, frame size zero acting as one.
        reg_write(REG_K_TOP, {16'h7fff, 16'h8000, 16'h4000});
        reg_write(REG_K_MID, {16'hffff, 16'h0001, 16'h8000});
        reg_write(REG_K_BOT, {16'h7fff, 16'h7fff, 16'h7fff});
        reg_write(REG_BIAS, 64'h8000_0000);
        reg_write(REG_FRAME, 64'd0);
        for (int i = 0; i < 9; i++)
            add_slot((i == 4) ? 32'h8000_0000 : 32'h7fff_ffff, 1'b1, 1'b1);
        gen_started[0] = 1'b1;
        drain();
        reg_write(REG_BIAS, 64'h7fff_ffff);
        reg_write(REG_FRAME, 64'd2);
        for (int i = 0; i < 16; i++)
            add_slot(rand_pixel(2), 1'b1, 1'b1);
        gen_started[0] = 1'b1; gen_started[1] = 1'b1;
        gen_started[MAX_SIZE] = 1'b1; gen_started[MAX_SIZE+1] = 1'b1;
        drain();

        // Accumulate twenty planes of extreme pixels and weights into one position.
        reg_write(REG_K_TOP, {3{16'h7fff}});
        reg_write(REG_K_MID, {3{16'h7fff}});
        reg_write(REG_K_BOT, {3{16'h7fff}});
        reg_write(REG_BIAS, 64'h0);
        reg_write(REG_FRAME, 64'd1);
        for (int i = 0; i < 20; i++) begin
            for (int j = 0; j < 9; j++)
                add_slot((i % 2 == 0) ? 32'h7fff_ffff : 32'h7fff_0000, i == 0, 1'b1);
        end
        drain();

        // Random phases, mostly small frames.
        while (gen_items < 680) begin
            reg_write(REG_K_TOP, rand_kernel($urandom_range(0, 2)));
            reg_write(REG_K_MID, rand_kernel($urandom_range(0, 2)));
            reg_write(REG_K_BOT, rand_kernel($urandom_range(0, 2)));
            reg_write(REG_BIAS, ($urandom_range(0, 1) != 0) ? 64'($urandom) :
                      64'($urandom_range(0, 1 << 20)));
            reg_write(REG_FRAME, 64'($urandom_range(0, 6)));
            pmode = $urandom_range(0, 2);
            nplanes = $urandom_range(1, 4);
            for (int i = 0; i < nplanes; i++)
                add_plane(pmode, i == 0, i == nplanes - 1 || $urandom_range(0, 1) != 0);
            drain();
        end

        // Out-of-range write followed by a small plane.
        reg_write(REG_FRAME, 64'd511);
        reg_write(REG_K_TOP, rand_kernel(1));
        reg_write(REG_BIAS, 64'($urandom_range(0, 1 << 16)));
        reg_write(REG_FRAME, 64'd3);
        add_plane(0, 1'b1, 1'b1);
        drain();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
